@@ hdl/sliding_window_zscore_detector_core_defines.svh @@
// Assertion macros shared by the detector RTL.
`ifndef SLIDING_WINDOW_ZSCORE_DETECTOR_CORE_DEFINES_SVH
`define SLIDING_WINDOW_ZSCORE_DETECTOR_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define SWZ_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the same cycle as a trigger.
`define SWZ_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/swz_pkg.sv @@
// Shared constants, codes and structures of the z-score detector.
package swz_pkg;

   localparam int WINDOW_MAX  = 64;
   localparam int WINDOW_MIN  = 4;
   localparam int LEN_DEFAULT = (32 <= WINDOW_MAX) ? 32 : WINDOW_MAX;
   localparam int ADDR_W      = $clog2(WINDOW_MAX);
   localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
   localparam int MINS_RESET  = 5;
   localparam int ZLIM_RESET  = 768;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;
   localparam int ZLIM_W     = 15;

   localparam int TEMP_W  = 16;
   localparam int HUM_W   = 14;
   localparam int LIGHT_W = 12;

   // Datapath widths of the statistics.
   localparam int SMP_W   = 16;
   localparam int SQ_W    = 2 * SMP_W - 1;
   localparam int S_W     = SMP_W + CNT_W;
   localparam int Q_W     = SQ_W + CNT_W;
   localparam int CQ_W    = Q_W + CNT_W;
   localparam int D_W     = CQ_W;
   localparam int N_W     = SMP_W + CNT_W + 1;
   localparam int AN_W    = N_W - 1;
   localparam int N2_W    = 2 * AN_W;
   localparam int MSTEP_W = $clog2(AN_W);

   // Divider and square root.
   localparam int LIGHT_SH   = 8;
   localparam int HUNDRED_W  = AN_W + 7;
   localparam int NUM_W      = HUNDRED_W + LIGHT_SH;
   localparam int STEP_W     = $clog2(NUM_W + 1);
   localparam int RATIO_FRAC = 16;
   localparam int SAT_EXP    = 14;
   localparam int ROOT_W     = 15;
   localparam int RAD_W      = SAT_EXP + RATIO_FRAC;
   localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);
   localparam int REM_W      = ROOT_W + 4;

   localparam int Z_W   = 16;
   localparam int MAG_W = 16;
   localparam int Z_SAT = 32768;
   localparam int Z_MAX = 32767;

   localparam logic FUNC_PUSH  = 1'b0;
   localparam logic FUNC_CHECK = 1'b1;

   localparam logic [1:0] CH_TEMP  = 2'd0;
   localparam logic [1:0] CH_HUM   = 2'd1;
   localparam logic [1:0] CH_LIGHT = 2'd2;
   localparam logic [1:0] CH_NONE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SAMPLES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Z_LIMIT       = 2'd2;

   typedef struct packed {
      logic                    start;
      logic [1:0]              chan;
      logic signed [SMP_W-1:0] value;
      logic [CNT_W-1:0]        count;
   } job_type;

   typedef struct packed {
      logic                  valid;
      logic signed [Z_W-1:0] z_score;
      logic                  anomaly;
      logic [CNT_W-1:0]      samples_used;
   } res_type;

   typedef struct packed {
      logic              start;
      logic [D_W-1:0]    pr_init;
      logic [NUM_W-1:0]  num;
      logic [D_W-1:0]    divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_stat_type;

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_stat_type;

endpackage

@@ hdl/swz_if.sv @@
// Request and response channel interfaces of the detector.
interface swz_req_if import swz_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic [1:0]               channel;
   logic signed [TEMP_W-1:0] temp_value;
   logic [HUM_W-1:0]         hum_value;
   logic [LIGHT_W-1:0]       light_value;

   modport source (output valid, func, channel, temp_value, hum_value, light_value,
                   input ready);
   modport sink (input valid, func, channel, temp_value, hum_value, light_value,
                 output ready);
endinterface

interface swz_rsp_if import swz_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [Z_W-1:0] z_score;
   logic                  anomaly;
   logic [CNT_W-1:0]      samples_used;

   modport source (output valid, z_score, anomaly, samples_used, input ready);
   modport sink (input valid, z_score, anomaly, samples_used, output ready);
endinterface

@@ hdl/swz_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module swz_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/swz_div.sv @@
// Restoring divider that retires one quotient bit per cycle.
module swz_div import swz_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  div_req,
   output div_stat_type div_stat
);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [D_W-1:0]    pr_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [D_W-1:0]    divs_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [D_W:0]      trial;
   logic              fits;

   assign trial = {pr_ff, num_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, divs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= div_req.steps;
            pr_ff   <= div_req.pr_init;
            num_ff  <= div_req.num;
            divs_ff <= div_req.divisor;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            if (fits) begin
               pr_ff <= D_W'(trial - {1'b0, divs_ff});
            end else begin
               pr_ff <= trial[D_W-1:0];
            end
            quo_ff <= {quo_ff[NUM_W-2:0], fits};
            num_ff <= {num_ff[NUM_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_stat.busy     = busy_ff;
   assign div_stat.done     = done_ff;
   assign div_stat.quotient = quo_ff;

endmodule

@@ hdl/swz_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
module swz_sqrt import swz_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  sqrt_req_type  sqrt_req,
   output sqrt_stat_type sqrt_stat
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [ROOT_CNT_W-1:0] cnt_ff;
   logic [RAD_W-1:0]      rad_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic [REM_W-1:0]      cur;
   logic [REM_W-1:0]      trial;

   assign cur   = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial = REM_W'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (sqrt_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ROOT_CNT_W'(ROOT_W);
            rad_ff  <= sqrt_req.radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            if (cur >= trial) begin
               rem_ff  <= cur - trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= cur;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
            rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == ROOT_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sqrt_stat.busy = busy_ff;
   assign sqrt_stat.done = done_ff;
   assign sqrt_stat.root = root_ff;

endmodule

@@ hdl/swz_engine.sv @@
// Check sequencer: window sums, bit-serial products, divide and root.
`include "sliding_window_zscore_detector_core_defines.svh"
module swz_engine import swz_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  job_type                 job,
   input  logic [CNT_W-1:0]        min_samples,
   input  logic [ZLIM_W-1:0]       z_limit,
   input  logic signed [SMP_W-1:0] rd_data,
   input  logic                    res_take,
   output logic [ADDR_W-1:0]       rd_addr,
   output res_type                 res,
   output logic                    idle
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_MULC, ST_NPREP, ST_MULS, ST_DPREP,
      ST_DSEL, ST_DIV, ST_SQRT, ST_FIN, ST_OUT
   } state_type;

   state_type st_ff;

   logic [1:0]              chan_ff;
   logic signed [SMP_W-1:0] val_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]        rd_idx_ff;
   logic                    vld1_ff;
   logic                    vld2_ff;
   logic signed [SMP_W-1:0] x_ff;
   logic [SQ_W-1:0]         sq_ff;
   logic signed [S_W-1:0]   s_ff;
   logic [Q_W-1:0]          q_ff;
   logic [MSTEP_W-1:0]      step_ff;
   logic [CNT_W-1:0]        mc_ff;
   logic [CQ_W-1:0]         qsh_ff;
   logic signed [N_W-1:0]   vsh_ff;
   logic [CQ_W-1:0]         cq_ff;
   logic signed [N_W-1:0]   cv_ff;
   logic signed [N_W-1:0]   n_ff;
   logic [AN_W-1:0]         an_ff;
   logic [AN_W-1:0]         ms_ff;
   logic [AN_W-1:0]         ma_ff;
   logic [CQ_W-1:0]         ssh_ff;
   logic [N2_W-1:0]         ash_ff;
   logic [CQ_W-1:0]         ss_ff;
   logic [N2_W-1:0]         n2_ff;
   logic [D_W-1:0]          d_ff;
   logic [HUNDRED_W-1:0]    h_ff;
   logic                    flr_ff;
   logic [MAG_W-1:0]        mag_ff;
   res_type                 res_ff;
   div_req_type             div_req_ff;
   sqrt_req_type            sqrt_req_ff;

   div_stat_type            div_stat;
   sqrt_stat_type           sqrt_stat;

   logic signed [2*SMP_W-1:0] sq_full;
   logic signed [N_W-1:0]     n_in;
   logic [2*CNT_W-1:0]        cc;
   logic                      floored;
   logic [N2_W-1:0]           n2_hi;
   logic [MAG_W-1:0]          z_pos;
   logic [MAG_W-1:0]          abs_z;

   assign sq_full = rd_data * rd_data;
   assign n_in    = cv_ff - N_W'(s_ff);
   assign cc      = cnt_ff * cnt_ff;
   assign floored = (chan_ff == CH_LIGHT) ? (d_ff < D_W'(cc)) : (d_ff == '0);
   assign n2_hi   = n2_ff >> SAT_EXP;
   assign z_pos   = (mag_ff > MAG_W'(Z_MAX)) ? MAG_W'(Z_MAX) : mag_ff;
   assign abs_z   = n_ff[N_W-1] ? mag_ff : z_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff             <= ST_IDLE;
         cnt_ff            <= '0;
         rd_idx_ff         <= '0;
         vld1_ff           <= 1'b0;
         vld2_ff           <= 1'b0;
         res_ff.valid      <= 1'b0;
         div_req_ff.start  <= 1'b0;
         sqrt_req_ff.start <= 1'b0;
      end else begin
         div_req_ff.start  <= 1'b0;
         sqrt_req_ff.start <= 1'b0;
         unique case (st_ff)
            ST_IDLE: begin
               if (job.start) begin
                  chan_ff   <= job.chan;
                  val_ff    <= job.value;
                  cnt_ff    <= job.count;
                  rd_idx_ff <= '0;
                  s_ff      <= '0;
                  q_ff      <= '0;
                  if (job.count == '0 || job.count < min_samples) begin
                     res_ff.valid        <= 1'b1;
                     res_ff.z_score      <= '0;
                     res_ff.anomaly      <= 1'b0;
                     res_ff.samples_used <= '0;
                     st_ff               <= ST_OUT;
                  end else begin
                     st_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               // Address, RAM data and square each take one register stage.
               if (rd_idx_ff < cnt_ff) begin
                  rd_idx_ff <= rd_idx_ff + 1'b1;
                  vld1_ff   <= 1'b1;
               end else begin
                  vld1_ff <= 1'b0;
               end
               vld2_ff <= vld1_ff;
               if (vld1_ff) begin
                  x_ff  <= rd_data;
                  sq_ff <= sq_full[SQ_W-1:0];
               end
               if (vld2_ff) begin
                  s_ff <= s_ff + S_W'(x_ff);
                  q_ff <= q_ff + Q_W'(sq_ff);
               end
               if (rd_idx_ff == cnt_ff && !vld1_ff && !vld2_ff) begin
                  mc_ff   <= cnt_ff;
                  qsh_ff  <= CQ_W'(q_ff);
                  vsh_ff  <= N_W'(val_ff);
                  cq_ff   <= '0;
                  cv_ff   <= '0;
                  step_ff <= '0;
                  st_ff   <= ST_MULC;
               end
            end
            ST_MULC: begin
               // c*Q and c*value share the bits of the count.
               if (mc_ff[0]) begin
                  cq_ff <= cq_ff + qsh_ff;
                  cv_ff <= cv_ff + vsh_ff;
               end
               mc_ff   <= mc_ff >> 1;
               qsh_ff  <= qsh_ff << 1;
               vsh_ff  <= vsh_ff <<< 1;
               step_ff <= step_ff + 1'b1;
               if (step_ff == MSTEP_W'(CNT_W - 1)) begin
                  st_ff <= ST_NPREP;
               end
            end
            ST_NPREP: begin
               n_ff    <= n_in;
               an_ff   <= n_in[N_W-1] ? AN_W'(-n_in) : AN_W'(n_in);
               ms_ff   <= s_ff[S_W-1] ? AN_W'(-s_ff) : AN_W'(s_ff);
               ma_ff   <= n_in[N_W-1] ? AN_W'(-n_in) : AN_W'(n_in);
               ssh_ff  <= s_ff[S_W-1] ? CQ_W'(-s_ff) : CQ_W'(s_ff);
               ash_ff  <= n_in[N_W-1] ? N2_W'(-n_in) : N2_W'(n_in);
               ss_ff   <= '0;
               n2_ff   <= '0;
               step_ff <= '0;
               st_ff   <= ST_MULS;
            end
            ST_MULS: begin
               // S*S and |n|*|n| in parallel.
               if (ms_ff[0]) begin
                  ss_ff <= ss_ff + ssh_ff;
               end
               if (ma_ff[0]) begin
                  n2_ff <= n2_ff + ash_ff;
               end
               ms_ff   <= ms_ff >> 1;
               ma_ff   <= ma_ff >> 1;
               ssh_ff  <= ssh_ff << 1;
               ash_ff  <= ash_ff << 1;
               step_ff <= step_ff + 1'b1;
               if (step_ff == MSTEP_W'(AN_W - 1)) begin
                  st_ff <= ST_DPREP;
               end
            end
            ST_DPREP: begin
               d_ff  <= (cq_ff >= ss_ff) ? D_W'(cq_ff - ss_ff) : '0;
               h_ff  <= HUNDRED_W'({an_ff, 6'b0}) + HUNDRED_W'({an_ff, 5'b0})
                        + HUNDRED_W'({an_ff, 2'b0});
               st_ff <= ST_DSEL;
            end
            ST_DSEL: begin
               if (floored) begin
                  flr_ff             <= 1'b1;
                  div_req_ff.start   <= 1'b1;
                  div_req_ff.pr_init <= '0;
                  div_req_ff.num     <= (chan_ff == CH_LIGHT)
                                        ? NUM_W'(an_ff) << LIGHT_SH
                                        : NUM_W'(h_ff) << LIGHT_SH;
                  div_req_ff.divisor <= D_W'(cnt_ff);
                  div_req_ff.steps   <= STEP_W'(NUM_W);
                  st_ff              <= ST_DIV;
               end else if (D_W'(n2_hi) >= d_ff) begin
                  // Ratio of at least 2^14 saturates before the root.
                  mag_ff <= MAG_W'(Z_SAT);
                  st_ff  <= ST_FIN;
               end else begin
                  flr_ff             <= 1'b0;
                  div_req_ff.start   <= 1'b1;
                  div_req_ff.pr_init <= D_W'(n2_hi);
                  div_req_ff.num     <= NUM_W'(n2_ff[SAT_EXP-1:0]) << (NUM_W - SAT_EXP);
                  div_req_ff.divisor <= d_ff;
                  div_req_ff.steps   <= STEP_W'(RAD_W);
                  st_ff              <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_stat.done) begin
                  if (flr_ff) begin
                     mag_ff <= (div_stat.quotient >= NUM_W'(Z_SAT))
                               ? MAG_W'(Z_SAT) : div_stat.quotient[MAG_W-1:0];
                     st_ff  <= ST_FIN;
                  end else begin
                     sqrt_req_ff.start    <= 1'b1;
                     sqrt_req_ff.radicand <= div_stat.quotient[RAD_W-1:0];
                     st_ff                <= ST_SQRT;
                  end
               end
            end
            ST_SQRT: begin
               if (sqrt_stat.done) begin
                  mag_ff <= MAG_W'(sqrt_stat.root);
                  st_ff  <= ST_FIN;
               end
            end
            ST_FIN: begin
               res_ff.valid        <= 1'b1;
               res_ff.z_score      <= n_ff[N_W-1] ? $signed(MAG_W'(0) - mag_ff)
                                                  : $signed(z_pos);
               res_ff.anomaly      <= abs_z > MAG_W'(z_limit);
               res_ff.samples_used <= cnt_ff;
               st_ff               <= ST_OUT;
            end
            ST_OUT: begin
               if (res_take) begin
                  res_ff.valid <= 1'b0;
                  st_ff        <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   swz_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req_ff),
      .div_stat (div_stat)
   );

   swz_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .sqrt_req  (sqrt_req_ff),
      .sqrt_stat (sqrt_stat)
   );

   assign rd_addr = rd_idx_ff[ADDR_W-1:0];
   assign res     = res_ff;
   assign idle    = (st_ff == ST_IDLE);

   `SWZ_ASSERT_IMPLY(a_div_start_idle, clock, reset, div_req_ff.start, !div_stat.busy, "divider restarted while busy")
   `SWZ_ASSERT_IMPLY(a_sqrt_start_idle, clock, reset, sqrt_req_ff.start, !sqrt_stat.busy, "root unit restarted while busy")
   `SWZ_ASSERT_ALWAYS(a_rd_idx_bound, clock, reset, rd_idx_ff <= cnt_ff, "window read ran past the held count")

endmodule

@@ hdl/sliding_window_zscore_detector_core.sv @@
// Sliding-window z-score detector: registers, ring windows and response stage.
// A push request stores one temperature, humidity and light sample in three
// 64-entry ring RAMs. A check request scans the held samples of one channel
// at one RAM read per cycle, forms the sums and products with bit-serial
// shift-add steps, and finishes with a restoring divider and a digit-by-digit
// square root. A check with too few samples skips the scan and answers with
// a zero score, and a check of channel three gives no response. Requests are
// taken one at a time; a finished result waits in the output register without
// holding up the next request. Writing the window length register restarts
// the window; there is no clearing pass.
`include "sliding_window_zscore_detector_core_defines.svh"
module sliding_window_zscore_detector_core import swz_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   swz_req_if.sink               req_ch,
   swz_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CNT_W-1:0]  wlen_ff;
   logic [CNT_W-1:0]  mins_ff;
   logic [ZLIM_W-1:0] zlim_ff;
   logic [ADDR_W-1:0] wp_ff;
   logic              full_ff;
   logic [1:0]        sel_chan_ff;
   logic              rsp_valid_ff;
   res_type           rsp_ff;

   logic              req_take;
   logic              push;
   logic [CNT_W-1:0]  wp_inc;
   logic [CNT_W-1:0]  len_in;
   logic [CNT_W-1:0]  held;
   job_type           job;
   res_type           res;
   logic              eng_idle;
   logic              res_take;
   logic [ADDR_W-1:0] rd_addr;
   logic [TEMP_W-1:0]  rd_temp;
   logic [HUM_W-1:0]   rd_hum;
   logic [LIGHT_W-1:0] rd_light;
   logic signed [SMP_W-1:0] rd_sel;

   assign req_ch.ready = eng_idle;
   assign req_take     = req_ch.valid && eng_idle;
   assign push         = req_take && (req_ch.func == FUNC_PUSH);
   assign wp_inc       = CNT_W'(wp_ff) + 1'b1;
   assign len_in       = (csr_wdata[CNT_W-1:0] >= CNT_W'(WINDOW_MIN)
                          && csr_wdata[CNT_W-1:0] <= CNT_W'(WINDOW_MAX))
                         ? csr_wdata[CNT_W-1:0] : CNT_W'(LEN_DEFAULT);
   assign held         = full_ff ? wlen_ff : CNT_W'(wp_ff);

   always_comb begin
      job.start = req_take && (req_ch.func == FUNC_CHECK) && (req_ch.channel != CH_NONE);
      job.chan  = req_ch.channel;
      job.count = held;
      case (req_ch.channel)
         CH_TEMP: job.value = req_ch.temp_value;
         CH_HUM:  job.value = $signed(SMP_W'(req_ch.hum_value));
         default: job.value = $signed(SMP_W'(req_ch.light_value));
      endcase
   end

   always_comb begin
      case (sel_chan_ff)
         CH_TEMP: rd_sel = $signed(rd_temp);
         CH_HUM:  rd_sel = $signed(SMP_W'(rd_hum));
         default: rd_sel = $signed(SMP_W'(rd_light));
      endcase
   end

   assign res_take = res.valid && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff      <= CNT_W'(LEN_DEFAULT);
         mins_ff      <= CNT_W'(MINS_RESET);
         zlim_ff      <= ZLIM_W'(ZLIM_RESET);
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_WINDOW_LENGTH: begin
                  wlen_ff <= len_in;
                  wp_ff   <= '0;
                  full_ff <= 1'b0;
               end
               REG_MIN_SAMPLES: mins_ff <= csr_wdata[CNT_W-1:0];
               REG_Z_LIMIT:     zlim_ff <= csr_wdata[ZLIM_W-1:0];
               default: ;
            endcase
         end
         if (push) begin
            if (wp_inc >= wlen_ff) begin
               wp_ff   <= '0;
               full_ff <= 1'b1;
            end else begin
               wp_ff <= wp_inc[ADDR_W-1:0];
            end
         end
         if (res_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job.start) begin
         sel_chan_ff <= req_ch.channel;
      end
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   swz_ram #(.WIDTH(TEMP_W), .DEPTH(WINDOW_MAX)) u_temp_ram (
      .clock (clock),
      .we    (push),
      .waddr (wp_ff),
      .wdata (req_ch.temp_value),
      .raddr (rd_addr),
      .rdata (rd_temp)
   );

   swz_ram #(.WIDTH(HUM_W), .DEPTH(WINDOW_MAX)) u_hum_ram (
      .clock (clock),
      .we    (push),
      .waddr (wp_ff),
      .wdata (req_ch.hum_value),
      .raddr (rd_addr),
      .rdata (rd_hum)
   );

   swz_ram #(.WIDTH(LIGHT_W), .DEPTH(WINDOW_MAX)) u_light_ram (
      .clock (clock),
      .we    (push),
      .waddr (wp_ff),
      .wdata (req_ch.light_value),
      .raddr (rd_addr),
      .rdata (rd_light)
   );

   swz_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .job         (job),
      .min_samples (mins_ff),
      .z_limit     (zlim_ff),
      .rd_data     (rd_sel),
      .res_take    (res_take),
      .rd_addr     (rd_addr),
      .res         (res),
      .idle        (eng_idle)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.z_score      = rsp_ff.z_score;
   assign rsp_ch.anomaly      = rsp_ff.anomaly;
   assign rsp_ch.samples_used = rsp_ff.samples_used;

   `SWZ_ASSERT_ALWAYS(a_wp_in_window, clock, reset, CNT_W'(wp_ff) < wlen_ff, "write pointer outside the window")

endmodule

@@ tb/sv/zscore_result_checker.sv @@
// Watches the detector channels, predicts each check result and compares it.
`timescale 1ns / 100ps
module zscore_result_checker import swz_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   swz_req_if                    req_mon,
   swz_rsp_if                    rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    pending_count
);

   typedef struct {
      logic signed [Z_W-1:0] z_score;
      logic                  anomaly;
      logic [CNT_W-1:0]      samples_used;
   } z_result_type;

   z_result_type z_expect_q[$];

   int unsigned win_len;
   int unsigned min_held;
   int unsigned z_thresh;
   int unsigned wr_ptr;
   bit          win_full;
   longint      temp_ring[WINDOW_MAX];
   longint      hum_ring[WINDOW_MAX];
   longint      light_ring[WINDOW_MAX];

   function automatic int unsigned int_sqrt(input int unsigned x);
      int unsigned r;
      int unsigned b;
      r = 0;
      b = 32'h4000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // floor(256*a/sqrt(d)), capped at the saturation magnitude.
   function automatic int unsigned root_ratio(input longint unsigned a,
                                              input longint unsigned d);
      longint unsigned sq;
      longint unsigned quo;
      longint unsigned rem;
      sq  = a * a;
      quo = sq / d;
      rem = sq % d;
      if (quo >= (64'd1 << SAT_EXP)) return Z_SAT;
      for (int i = 0; i < RATIO_FRAC; i++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= d) begin
            rem = rem - d;
            quo = quo | 64'd1;
         end
      end
      return int_sqrt(32'(quo));
   endfunction

   function automatic z_result_type detector_z_predict(input logic [1:0] chan,
                                                       input longint value);
      z_result_type    res;
      int unsigned     held;
      int unsigned     mag;
      longint          sum;
      longint          sumsq;
      longint          dev;
      longint          num;
      longint          x;
      longint unsigned anum;
      longint unsigned held_sq;
      longint unsigned m;
      bit              floored;
      held = win_full ? win_len : wr_ptr;
      res.z_score = '0;
      res.anomaly = 1'b0;
      res.samples_used = '0;
      if (held == 0 || held < min_held) return res;
      sum = 0;
      sumsq = 0;
      for (int i = 0; i < held; i++) begin
         if (chan == CH_TEMP) x = temp_ring[i];
         else if (chan == CH_HUM) x = hum_ring[i];
         else x = light_ring[i];
         sum = sum + x;
         sumsq = sumsq + x * x;
      end
      dev = longint'(held) * sumsq - sum * sum;
      if (dev < 0) dev = 0;
      num = longint'(held) * value - sum;
      anum = (num < 0) ? -num : num;
      held_sq = held * held;
      if (chan == CH_LIGHT) floored = dev < held_sq;
      else floored = (dev < held_sq) && (dev * 10000 < held_sq);
      if (floored || dev == 0) begin
         m = anum * ((chan == CH_LIGHT) ? 256 : 25600) / held;
         mag = (m >= Z_SAT) ? Z_SAT : 32'(m);
      end else begin
         mag = root_ratio(anum, dev);
      end
      if (num < 0) begin
         res.z_score = Z_W'(-int'(mag));
      end else begin
         if (mag > Z_MAX) mag = Z_MAX;
         res.z_score = Z_W'(mag);
      end
      res.anomaly = mag > z_thresh;
      res.samples_used = CNT_W'(held);
      return res;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count = error_count + 1;
   endtask

   always @(posedge clock) begin
      z_result_type want;
      longint       value;
      if (reset) begin
         win_len  = LEN_DEFAULT;
         min_held = MINS_RESET;
         z_thresh = ZLIM_RESET;
         wr_ptr   = 0;
         win_full = 0;
         error_count = 0;
         z_expect_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (z_expect_q.size() == 0) begin
               report("unexpected response count", 1, 0);
            end else begin
               want = z_expect_q.pop_front();
               if (rsp_mon.z_score !== want.z_score)
                  report("z_score", rsp_mon.z_score, want.z_score);
               if (rsp_mon.anomaly !== want.anomaly)
                  report("anomaly", rsp_mon.anomaly, want.anomaly);
               if (rsp_mon.samples_used !== want.samples_used)
                  report("samples_used", rsp_mon.samples_used, want.samples_used);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_PUSH) begin
               if (wr_ptr < WINDOW_MAX) begin
                  temp_ring[wr_ptr]  = req_mon.temp_value;
                  hum_ring[wr_ptr]   = req_mon.hum_value;
                  light_ring[wr_ptr] = req_mon.light_value;
               end
               wr_ptr = wr_ptr + 1;
               if (wr_ptr >= win_len) begin
                  wr_ptr = 0;
                  win_full = 1;
               end
            end else if (req_mon.channel != CH_NONE) begin
               if (req_mon.channel == CH_TEMP) value = req_mon.temp_value;
               else if (req_mon.channel == CH_HUM) value = req_mon.hum_value;
               else value = req_mon.light_value;
               z_expect_q.push_back(detector_z_predict(req_mon.channel, value));
            end
         end
         if (csr_we) begin
            if (csr_index == REG_WINDOW_LENGTH) begin
               win_len = (csr_wdata[6:0] >= WINDOW_MIN && csr_wdata[6:0] <= WINDOW_MAX) ?
                         csr_wdata[6:0] : LEN_DEFAULT;
               wr_ptr = 0;
               win_full = 0;
            end else if (csr_index == REG_MIN_SAMPLES) begin
               min_held = csr_wdata[6:0];
            end else if (csr_index == REG_Z_LIMIT) begin
               z_thresh = csr_wdata[14:0];
            end
         end
      end
      pending_count = z_expect_q.size();
   end

endmodule

@@ tb/sv/sliding_window_zscore_detector_core_tb.sv @@
// Stimulus, receiver stalls and verdict for the z-score detector.
`timescale 1ns / 100ps
module sliding_window_zscore_detector_core_tb import swz_pkg::*; ();

   localparam int IDLE_LIMIT  = 20000;
   localparam int DRAIN_WAIT  = 250;
   localparam int PHASE_ITEMS = 110;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  hold_off;
   int                    error_count;
   int                    pending_count;
   int                    idle_cycles;
   int                    burst_left;
   int                    temp_base, hum_base, light_base, spread;

   swz_req_if req_ch ();
   swz_rsp_if rsp_ch ();

   sliding_window_zscore_detector_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   zscore_result_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The receiver alternates between always-ready runs and random stalls.
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_ch.ready <= 1'b0;
      end else if (($time / 2000) % 3 == 0) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // One long hold-off early in the random part lets requests back up.
   initial begin
      hold_off = 1'b0;
      #20000;
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (600) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[sliding_window_zscore_detector_core] ERROR");
            $finish;
         end
      end
   end

   task automatic send_request(input logic func, input logic [1:0] chan,
                               input int tv, input int hv, input int lv);
      req_ch.valid       <= 1'b1;
      req_ch.func        <= func;
      req_ch.channel     <= chan;
      req_ch.temp_value  <= tv[TEMP_W-1:0];
      req_ch.hum_value   <= hv[HUM_W-1:0];
      req_ch.light_value <= lv[LIGHT_W-1:0];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 1)) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   endtask

   task automatic quiesce();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_regs(input int len, input int mins, input int zlim);
      csr_we    <= 1'b1;
      csr_index <= REG_WINDOW_LENGTH;
      csr_wdata <= CSR_DATA_W'(len);
      @(posedge clock);
      csr_index <= REG_MIN_SAMPLES;
      csr_wdata <= CSR_DATA_W'(mins);
      @(posedge clock);
      csr_index <= REG_Z_LIMIT;
      csr_wdata <= CSR_DATA_W'(zlim);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int near(input int base, input int width);
      return base + $urandom_range(0, 2 * width) - width;
   endfunction

   task automatic random_item();
      int pick;
      int scale;
      pick = $urandom_range(0, 99);
      scale = (spread == 0) ? 1 : spread;
      if (pick < 35) begin
         send_request(FUNC_PUSH, CH_TEMP, near(temp_base, spread),
                      near(hum_base, spread), near(light_base, spread));
      end else if (pick < 40) begin
         send_request(FUNC_CHECK, CH_NONE, $urandom, $urandom, $urandom);
      end else if (pick < 50) begin
         send_request(FUNC_CHECK, 2'($urandom_range(0, 2)), $urandom, $urandom, $urandom);
      end else begin
         send_request(FUNC_CHECK, 2'($urandom_range(0, 2)), near(temp_base, 4 * scale),
                      near(hum_base, 4 * scale), near(light_base, 4 * scale));
      end
   endtask

   initial begin
      int cfg_len[8]  = '{32, 4, 64, 0, 127, 3, 65, 16};
      int cfg_min[8]  = '{5, 1, 64, 0, 127, 3, 2, 8};
      int cfg_zl[8]   = '{768, 0, 32767, 256, 512, 1000, 100, 2000};
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = REG_WINDOW_LENGTH;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.func  = FUNC_PUSH;
      req_ch.channel = CH_TEMP;
      req_ch.temp_value = '0;
      req_ch.hum_value = '0;
      req_ch.light_value = '0;
      burst_left   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: too few samples, channel three, field extremes, flat windows.
      send_request(FUNC_CHECK, CH_TEMP, 100, 100, 100);
      send_request(FUNC_CHECK, CH_NONE, 0, 0, 0);
      send_request(FUNC_PUSH, CH_TEMP, -32768, 0, 0);
      send_request(FUNC_PUSH, CH_TEMP, 32767, 16383, 4095);
      send_request(FUNC_PUSH, CH_TEMP, 0, 10000, 2048);
      send_request(FUNC_PUSH, CH_TEMP, -1, 5000, 1);
      send_request(FUNC_CHECK, CH_HUM, 0, 0, 0);
      send_request(FUNC_PUSH, CH_TEMP, 2500, 4000, 300);
      send_request(FUNC_CHECK, CH_TEMP, -32768, 0, 0);
      send_request(FUNC_CHECK, CH_TEMP, 32767, 0, 0);
      send_request(FUNC_CHECK, CH_HUM, 0, 16383, 0);
      send_request(FUNC_CHECK, CH_LIGHT, 0, 0, 4095);
      send_request(FUNC_CHECK, CH_LIGHT, 0, 0, 0);
      send_request(FUNC_CHECK, CH_TEMP, 2500, 4000, 300);
      quiesce();
      write_regs(4, 4, 0);
      repeat (4) send_request(FUNC_PUSH, CH_TEMP, 1234, 777, 55);
      send_request(FUNC_CHECK, CH_TEMP, 1234, 0, 0);
      send_request(FUNC_CHECK, CH_TEMP, 1235, 0, 0);
      send_request(FUNC_CHECK, CH_HUM, 0, 700, 0);
      send_request(FUNC_CHECK, CH_LIGHT, 0, 0, 56);
      send_request(FUNC_CHECK, CH_LIGHT, 0, 0, 4095);
      send_request(FUNC_PUSH, CH_TEMP, 1234, 777, 54);
      send_request(FUNC_CHECK, CH_LIGHT, 0, 0, 55);
      quiesce();

      for (int p = 0; p < 8; p++) begin
         if (p == 0) write_regs(LEN_DEFAULT, MINS_RESET, ZLIM_RESET);
         else if (p == 7) write_regs($urandom_range(4, 64), $urandom_range(1, 64),
                                     $urandom_range(0, 32767));
         else write_regs(cfg_len[p], cfg_min[p], cfg_zl[p]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 40 == 0) begin
               temp_base  = $urandom_range(0, 60000) - 30000;
               hum_base   = $urandom_range(0, 10000);
               light_base = $urandom_range(0, 4095);
               case ($urandom_range(0, 3))
                  0: spread = 0;
                  1: spread = $urandom_range(1, 3);
                  2: spread = $urandom_range(4, 200);
                  default: spread = $urandom_range(200, 3000);
               endcase
            end
            random_item();
         end
         quiesce();
      end

      if (error_count == 0) begin
         $display("[sliding_window_zscore_detector_core] OK");
      end else begin
         $display("[sliding_window_zscore_detector_core] ERROR");
      end
      $finish;
   end

endmodule
